@@ rtl/rc4_pkg.sv @@
// ----------------------------------------------------------------------------
// rc4_pkg - shared constants for the RC4 stream cipher
// Field widths, permutation size and input mode codes.
// ----------------------------------------------------------------------------
package rc4_pkg;

	// Byte and index widths
	localparam int DATA_W     = 8;
	localparam int IDX_W      = 8;
	localparam int PERM_DEPTH = 256;

	// Configuration register width
	localparam int KEY_W = 64;

	// Input mode codes
	localparam logic MODE_RESTART = 1'b0;
	localparam logic MODE_DATA    = 1'b1;

endpackage

@@ rtl/rc4_ifs.sv @@
// ----------------------------------------------------------------------------
// rc4_ifs - valid/ready channel interfaces for the RC4 stream cipher
// Request, response and key write channels, each with source and sink views.
// ----------------------------------------------------------------------------

// Request channel: one mode bit and one data byte per transaction
interface rc4_req_if
	import rc4_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              mode;
	logic [DATA_W-1:0] data_byte;

	modport source (output valid, output mode, output data_byte, input ready);
	modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

// Response channel: one processed byte per transaction
interface rc4_rsp_if
	import rc4_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] out_byte;
	logic              not_keyed;

	modport source (output valid, output out_byte, output not_keyed, input ready);
	modport sink   (input valid, input out_byte, input not_keyed, output ready);
endinterface

// Key write channel: one 64-bit key per transaction
interface rc4_cfg_if
	import rc4_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] cipher_key;

	modport source (output valid, output cipher_key, input ready);
	modport sink   (input valid, input cipher_key, output ready);
endinterface

@@ rtl/rc4_stream_cipher.sv @@
// ----------------------------------------------------------------------------
// rc4_stream_cipher - RC4 keystream generator and byte XOR
// Key schedule and byte generation over one 256 x 8 permutation RAM.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload               Transaction
//  req      sink       mode, data_byte       restart (mode 0) or one byte (mode 1)
//  rsp      source     out_byte, not_keyed   one result per byte request
//  cfg      sink       cipher_key            key write, always ready
//
//  Byte request: states S_P1, S_P2 and S_P3 do the read-modify-write of the swap
//  on the single-read, single-write permutation RAM; the next request is taken in S_P3.
//  Restart: S_FILL writes all 256 entries, then S_KA to S_KD run once per key schedule entry, no request taken.
//  Reset clears both indices and the keyed flag; the permutation is undefined
//  until a restart. Unkeyed bytes are registered straight through at accept.
//  A full response register stalls the request side; the key port never stalls.
//
module rc4_stream_cipher
	import rc4_pkg::*;
#(
	parameter int KEY_BYTES = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	rc4_req_if.sink req,
	rc4_rsp_if.source rsp,
	rc4_cfg_if.sink cfg
);

	localparam int KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
	localparam logic [KIDX_W-1:0] KIDX_LAST = KIDX_W'(KEY_BYTES - 1);
	localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(PERM_DEPTH - 1);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_FILL = 9'b000000010,
		S_KA   = 9'b000000100,
		S_KB   = 9'b000001000,
		S_KC   = 9'b000010000,
		S_KD   = 9'b000100000,
		S_P1   = 9'b001000000,
		S_P2   = 9'b010000000,
		S_P3   = 9'b100000000
	} state_t;

	state_t state_q;

	// Control state
	logic [IDX_W-1:0]  i_q, j_q, n_q, acc_q;
	logic [KIDX_W-1:0] kidx_q;
	logic              keyed_q;
	logic              fwd_q;
	logic [KEY_W-1:0]  key_q;
	logic              rsp_valid_q;

	// Payload registers
	logic [DATA_W-1:0] si_q, sj_q, sn_q, t_q, data_q;
	logic [DATA_W-1:0] out_byte_q;
	logic              not_keyed_q;

	// RAM port
	logic              wr_en, rd_en;
	logic [IDX_W-1:0]  wr_addr, rd_addr;
	logic [DATA_W-1:0] wr_data, rd_data;

	// Datapath
	logic              out_free, in_ready, accept;
	logic              start_data, pass, restart, load_out;
	logic [IDX_W-1:0]  i_inc, acc_nx, j_nx, t_nx;
	logic [DATA_W-1:0] si, ks, key_byte;

	rc4_ram #(
		.WIDTH (DATA_W),
		.DEPTH (PERM_DEPTH)
	) u_perm (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Handshake decode
	assign out_free   = !rsp_valid_q || rsp.ready;
	assign in_ready   = out_free && (state_q == S_IDLE || state_q == S_P3);
	assign accept     = req.valid && in_ready;
	assign restart    = accept && (req.mode == MODE_RESTART);
	assign start_data = accept && (req.mode == MODE_DATA) && keyed_q;
	assign pass       = accept && (req.mode == MODE_DATA) && !keyed_q;
	assign load_out   = pass || (state_q == S_P3 && out_free);

	assign req.ready = in_ready;
	assign cfg.ready = 1'b1;

	// Key byte for the current schedule position, cycled over KEY_BYTES
	assign key_byte = key_q[{kidx_q, 3'b000} +: DATA_W];

	// Step arithmetic
	assign i_inc  = i_q + IDX_W'(1);
	assign acc_nx = acc_q + rd_data + key_byte;
	assign si     = fwd_q ? si_q : rd_data;
	assign j_nx   = j_q + si;
	assign t_nx   = si_q + rd_data;

	// Keystream byte: forward around the swap writes not yet seen by the read
	always_comb begin
		if (t_q == j_q) begin
			ks = si_q;
		end else if (t_q == i_q) begin
			ks = sj_q;
		end else begin
			ks = rd_data;
		end
	end

	// RAM address and write control
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = n_q;
		wr_data = n_q;
		rd_en   = 1'b0;
		rd_addr = i_inc;
		unique case (state_q)
			S_IDLE: begin
				rd_en = start_data;
			end
			S_FILL: begin
				wr_en = 1'b1;
			end
			S_KA: begin
				rd_en   = 1'b1;
				rd_addr = n_q;
			end
			S_KB: begin
				rd_en   = 1'b1;
				rd_addr = acc_nx;
			end
			S_KC: begin
				wr_en   = 1'b1;
				wr_data = rd_data;
			end
			S_KD: begin
				wr_en   = 1'b1;
				wr_addr = acc_q;
				wr_data = sn_q;
			end
			S_P1: begin
				rd_en   = 1'b1;
				rd_addr = j_nx;
			end
			S_P2: begin
				wr_en   = 1'b1;
				wr_addr = i_q;
				wr_data = rd_data;
				rd_en   = 1'b1;
				rd_addr = t_nx;
			end
			S_P3: begin
				wr_en   = 1'b1;
				wr_addr = j_q;
				wr_data = si_q;
				rd_en   = start_data;
			end
			default: begin
				wr_en = 1'b0;
				rd_en = 1'b0;
			end
		endcase
	end

	// Sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			n_q     <= '0;
			acc_q   <= '0;
			kidx_q  <= '0;
			keyed_q <= 1'b0;
			fwd_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (restart) begin
						n_q     <= '0;
						state_q <= S_FILL;
					end else if (start_data) begin
						i_q     <= i_inc;
						fwd_q   <= 1'b0;
						state_q <= S_P1;
					end
				end
				S_FILL: begin
					n_q <= n_q + IDX_W'(1);
					if (n_q == IDX_LAST) begin
						acc_q   <= '0;
						kidx_q  <= '0;
						state_q <= S_KA;
					end
				end
				S_KA: begin
					state_q <= S_KB;
				end
				S_KB: begin
					acc_q   <= acc_nx;
					state_q <= S_KC;
				end
				S_KC: begin
					state_q <= S_KD;
				end
				S_KD: begin
					n_q    <= n_q + IDX_W'(1);
					kidx_q <= (kidx_q == KIDX_LAST) ? '0 : kidx_q + KIDX_W'(1);
					if (n_q == IDX_LAST) begin
						i_q     <= '0;
						j_q     <= '0;
						keyed_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_KA;
					end
				end
				S_P1: begin
					j_q     <= j_nx;
					state_q <= S_P2;
				end
				S_P2: begin
					state_q <= S_P3;
				end
				S_P3: begin
					if (out_free) begin
						if (start_data) begin
							// next entry read races the pending S[j] write
							i_q     <= i_inc;
							fwd_q   <= (i_inc == j_q);
							state_q <= S_P1;
						end else if (restart) begin
							n_q     <= '0;
							state_q <= S_FILL;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Key register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg.valid) begin
			key_q <= cfg.cipher_key;
		end
	end

	// Response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Payload captures
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= req.data_byte;
		end
		if (state_q == S_KB) begin
			sn_q <= rd_data;
		end
		if (state_q == S_P1) begin
			si_q <= si;
		end
		if (state_q == S_P2) begin
			sj_q <= rd_data;
			t_q  <= t_nx;
		end
		if (pass) begin
			out_byte_q  <= req.data_byte;
			not_keyed_q <= 1'b1;
		end else if (load_out) begin
			out_byte_q  <= data_q ^ ks;
			not_keyed_q <= 1'b0;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.out_byte  = out_byte_q;
	assign rsp.not_keyed = not_keyed_q;

	// A blocked result keeps the last swap stage waiting
	a_p3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_P3 && !out_free) |=> (state_q == S_P3))
		else $error("byte step left stage 3 with response register full");

	// Schedule end clears both indices and marks the block keyed
	a_ksa_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_KD && n_q == IDX_LAST) |=>
		(keyed_q && i_q == '0 && j_q == '0 && state_q == S_IDLE))
		else $error("key schedule did not finish cleanly");

	// Byte steps run only after a key schedule
	a_step_keyed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_P1 || state_q == S_P2 || state_q == S_P3) |-> keyed_q)
		else $error("byte step without key schedule");

	// No permutation write while idle
	a_idle_nowr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !wr_en)
		else $error("permutation written while idle");

endmodule

@@ rtl/rc4_ram.sv @@
// ----------------------------------------------------------------------------
// rc4_ram - generic simple dual-port RAM
// One write port and one read port; read data registered, read-before-write.
// ----------------------------------------------------------------------------
module rc4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Same-address read returns the old contents
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

endmodule
